@@ rtl/core/twhs_pkg.sv @@
// Package for the task watchdog and heap supervisor.
// Holds the beat types, function codes, levels and limits; no dependencies.
package twhs_pkg;

    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] FN_PING  = 2'd0;
    localparam logic [1:0] FN_CHECK = 2'd1;
    localparam logic [1:0] FN_LOAD  = 2'd2;

    localparam logic [1:0] LVL_OK   = 2'd0;
    localparam logic [1:0] LVL_WARN = 2'd1;
    localparam logic [1:0] LVL_CRIT = 2'd2;

    localparam logic CAUSE_MEM  = 1'b0;
    localparam logic CAUSE_WDOG = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_CRIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_WARN = 1'd1;

    localparam logic [31:0] HEAP_CRIT_RST = 32'd16384;
    localparam logic [31:0] HEAP_WARN_RST = 32'd32768;

    localparam logic [7:0] CNT_MAX      = 8'hFF;
    localparam logic [7:0] STALE_LIMIT  = 8'd2;
    localparam logic [7:0] STRIKE_LIMIT = 8'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  task_id;
        logic [31:0] now_ms;
        logic [31:0] free_heap;
        logic [31:0] timeout_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  alive_mask;
        logic [1:0]  heap_level;
        logic [31:0] heap_low_mark;
        logic        reboot_request;
        logic        reboot_cause;
    } t_out_item;

    typedef struct packed {
        logic       alive;
        logic [7:0] stale_next;
        logic       trip;
    } t_slot_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_WALK,
        ST_HEAP,
        ST_EMIT
    } t_state;

endpackage

@@ rtl/core/twhs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module twhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/twhs_slot_eval.sv @@
// Shared slot comparator: judges one task slot alive or stale per cycle.
// Depends on twhs_pkg for the slot result type and limits.
module twhs_slot_eval import twhs_pkg::*; (
    input  logic [31:0] i_now,
    input  logic [31:0] i_stamp,
    input  logic [31:0] i_timeout,
    input  logic [7:0]  i_stale,
    output t_slot_res   o_res
);

    logic [32:0] diff;
    logic        alive;
    logic [7:0]  stale_next;

    // borrow out means the stamp is ahead of now
    assign diff  = {1'b0, i_now} - {1'b0, i_stamp};
    assign alive = (i_stamp == '0) || diff[32] || (diff[31:0] < i_timeout);

    always_comb begin
        if (alive) begin
            stale_next = '0;
        end else if (i_stale == CNT_MAX) begin
            stale_next = i_stale;
        end else begin
            stale_next = i_stale + 8'd1;
        end
    end

    assign o_res.alive      = alive;
    assign o_res.stale_next = stale_next;
    assign o_res.trip       = (stale_next >= STALE_LIMIT);

endmodule

@@ rtl/core/task_watchdog_heap_supervisor_unit.sv @@
// Task watchdog and heap supervisor, top level.
// Ping, load and other non-check codes go straight to the emit state; input stalls until loaded.
// Check: primes the RAM read, walks the slots, then judges the heap before the emit state;
// the walk takes one slot a cycle through the stamp/timeout RAM read port.
// Reset is synchronous, active low: clears counters, stamp valid bits and status,
// loads threshold defaults; timeout RAM is left uncleared.
module task_watchdog_heap_supervisor_unit import twhs_pkg::*; #(
    parameter int TASKS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int AW = (TASKS > 1) ? $clog2(TASKS) : 1;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_idx;
    logic [31:0]     r_crit, r_warn;
    logic [31:0]     r_now, r_free;
    logic [31:0]     r_min;
    logic [7:0]      r_strikes;
    logic [1:0]      r_sev;
    logic [7:0]      r_alive;
    logic            r_trip, r_req, r_cause;
    logic [7:0]      r_stale [TASKS];
    logic [TASKS-1:0] r_stamp_vld;
    logic            r_out_vld;
    t_out_item       r_out;

    logic            in_acc, id_ok, stamp_we, tmo_we;
    logic            last, walk_en, heap_en, out_free, out_load;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic [31:0]     stamp_rdata, tmo_rdata, stamp;
    t_slot_res       slot_res;
    logic            heap_crit, below_warn;
    logic [7:0]      n_strikes;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign id_ok       = (int'(i_in.task_id) < TASKS);
    assign wr_addr     = i_in.task_id[AW-1:0];
    assign stamp_we    = in_acc && (i_in.func == FN_PING) && id_ok;
    assign tmo_we      = in_acc && (i_in.func == FN_LOAD) && id_ok;
    assign last        = (r_idx == AW'(TASKS - 1));
    assign out_free    = !r_out_vld || !i_out_stall;

    twhs_ram #(.WIDTH(32), .DEPTH(TASKS), .AW(AW)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (wr_addr),
        .i_wdata (i_in.now_ms),
        .i_raddr (rd_addr),
        .o_rdata (stamp_rdata)
    );

    twhs_ram #(.WIDTH(32), .DEPTH(TASKS), .AW(AW)) u_tmo_ram (
        .i_clk   (i_clk),
        .i_we    (tmo_we),
        .i_waddr (wr_addr),
        .i_wdata (i_in.timeout_value),
        .i_raddr (rd_addr),
        .o_rdata (tmo_rdata)
    );

    assign stamp = r_stamp_vld[r_idx] ? stamp_rdata : '0;

    twhs_slot_eval u_slot_eval (
        .i_now     (r_now),
        .i_stamp   (stamp),
        .i_timeout (tmo_rdata),
        .i_stale   (r_stale[r_idx]),
        .o_res     (slot_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.func == FN_CHECK) ? ST_PRIME : ST_EMIT;
                end
            end
            ST_PRIME: n_state = ST_WALK;
            ST_WALK: begin
                if (last) begin
                    n_state = ST_HEAP;
                end
            end
            ST_HEAP: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        rd_addr  = '0;
        walk_en  = 1'b0;
        heap_en  = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ST_WALK: begin
                rd_addr = last ? r_idx : r_idx + AW'(1);
                walk_en = 1'b1;
            end
            ST_HEAP: heap_en  = 1'b1;
            ST_EMIT: out_load = out_free;
            default: rd_addr  = '0;
        endcase
    end

    assign heap_crit  = (r_free < r_crit);
    assign below_warn = (r_free < r_warn);

    always_comb begin
        if (!heap_crit) begin
            n_strikes = '0;
        end else if (r_strikes == CNT_MAX) begin
            n_strikes = r_strikes;
        end else begin
            n_strikes = r_strikes + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_crit      <= HEAP_CRIT_RST;
            r_warn      <= HEAP_WARN_RST;
            r_min       <= '1;
            r_strikes   <= '0;
            r_sev       <= LVL_OK;
            r_alive     <= '0;
            r_trip      <= 1'b0;
            r_req       <= 1'b0;
            r_cause     <= CAUSE_MEM;
            r_stamp_vld <= '0;
            r_out_vld   <= 1'b0;
            for (int i = 0; i < TASKS; i++) begin
                r_stale[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HEAP_CRIT: r_crit <= i_cfg_data;
                    CFG_HEAP_WARN: r_warn <= i_cfg_data;
                    default: r_crit <= r_crit;
                endcase
            end

            if (stamp_we) begin
                r_stamp_vld[wr_addr] <= 1'b1;
            end

            if (in_acc) begin
                r_req   <= 1'b0;
                r_cause <= CAUSE_MEM;
                r_trip  <= 1'b0;
                r_idx   <= '0;
            end

            if (walk_en) begin
                r_stale[r_idx] <= slot_res.stale_next;
                r_alive[r_idx] <= slot_res.alive;
                r_trip         <= r_trip || slot_res.trip;
                if (!last) begin
                    r_idx <= r_idx + AW'(1);
                end
            end

            if (heap_en) begin
                if (r_free < r_min) begin
                    r_min <= r_free;
                end
                r_strikes <= n_strikes;
                r_sev     <= heap_crit ? LVL_CRIT : (below_warn ? LVL_WARN : LVL_OK);
                if (n_strikes >= STRIKE_LIMIT) begin
                    r_req   <= 1'b1;
                    r_cause <= CAUSE_MEM;
                end else if (r_trip) begin
                    r_req   <= 1'b1;
                    r_cause <= CAUSE_WDOG;
                end
            end

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload of the check beat and of the result beat, held while stalled
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.func == FN_CHECK)) begin
            r_now  <= i_in.now_ms;
            r_free <= i_in.free_heap;
        end
        if (out_load) begin
            r_out.alive_mask     <= r_alive;
            r_out.heap_level     <= r_sev;
            r_out.heap_low_mark  <= r_min;
            r_out.reboot_request <= r_req;
            r_out.reboot_cause   <= r_cause;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_cause_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.reboot_cause |-> o_out.reboot_request)
        else $error("watchdog cause without reboot request");

    a_check_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in.func == FN_CHECK) |=> (r_state == ST_PRIME))
        else $error("check beat did not start the slot walk");

    a_low_mark_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_min <= $past(r_min)))
        else $error("heap low-water mark rose");

    a_level_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.heap_level != 2'd3))
        else $error("heap level out of range");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for task_watchdog_heap_supervisor_unit: directed and random beats,
// a local status predictor and a scoreboard. Depends on twhs_pkg and the unit only.
module tb_top;
    import twhs_pkg::*;

    localparam int          N_TASKS  = 8;
    localparam logic [1:0]  FN_SPARE = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    task_watchdog_heap_supervisor_unit #(
        .TASKS(N_TASKS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [31:0] pr_stamp [N_TASKS];
    logic [31:0] pr_tmo   [N_TASKS];
    logic [7:0]  pr_stale [N_TASKS];
    logic [7:0]  pr_strikes;
    logic [31:0] pr_low;
    logic [1:0]  pr_level;
    logic [7:0]  pr_alive;
    logic [31:0] pr_crit;
    logic [31:0] pr_warn;

    t_out_item   status_q [$];
    int          fail_count;
    bit          in_idle_en;
    bit          out_idle_en;
    int          hold_req;
    int          hold_seen;
    logic [31:0] clock_ms;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic t_out_item predict_status(input t_in_item it);
        t_out_item r;
        logic [7:0] mask;
        logic       trip;
        logic       live;
        int         i;
        r    = '0;
        mask = '0;
        trip = 1'b0;
        case (it.func)
            FN_PING: pr_stamp[it.task_id] = it.now_ms;
            FN_LOAD: pr_tmo[it.task_id] = it.timeout_value;
            FN_CHECK: begin
                if (it.free_heap < pr_low)
                    pr_low = it.free_heap;
                if (it.free_heap < pr_crit) begin
                    pr_level = LVL_CRIT;
                    if (pr_strikes != CNT_MAX)
                        pr_strikes = pr_strikes + 8'd1;
                end else if (it.free_heap < pr_warn) begin
                    pr_level   = LVL_WARN;
                    pr_strikes = '0;
                end else begin
                    pr_level   = LVL_OK;
                    pr_strikes = '0;
                end
                for (i = 0; i < N_TASKS; i++) begin
                    live = (pr_stamp[i] == '0) || (pr_stamp[i] > it.now_ms) ||
                           ((it.now_ms - pr_stamp[i]) < pr_tmo[i]);
                    if (live) begin
                        mask[i]     = 1'b1;
                        pr_stale[i] = '0;
                    end else if (pr_stale[i] != CNT_MAX) begin
                        pr_stale[i] = pr_stale[i] + 8'd1;
                    end
                    if (pr_stale[i] >= STALE_LIMIT)
                        trip = 1'b1;
                end
                pr_alive = mask;
                if (pr_strikes >= STRIKE_LIMIT) begin
                    r.reboot_request = 1'b1;
                    r.reboot_cause   = CAUSE_MEM;
                end else if (trip) begin
                    r.reboot_request = 1'b1;
                    r.reboot_cause   = CAUSE_WDOG;
                end
            end
            default: ;
        endcase
        r.alive_mask    = pr_alive;
        r.heap_level    = pr_level;
        r.heap_low_mark = pr_low;
        return r;
    endfunction

    function automatic t_in_item mk(input logic [1:0] fn, input logic [2:0] id,
                                    input logic [31:0] now, free, tmo);
        t_in_item it;
        it.func          = fn;
        it.task_id       = id;
        it.now_ms        = now;
        it.free_heap     = free;
        it.timeout_value = tmo;
        return it;
    endfunction

    function automatic logic [31:0] pick_heap();
        case ($urandom_range(4))
            0:       return pr_crit - $urandom_range(1, 3);
            1:       return pr_crit + $urandom_range(0, 2);
            2:       return pr_warn - $urandom_range(0, 2);
            3:       return pr_warn + $urandom_range(0, 2);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        while (in_idle_en && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        status_q.push_back(predict_status(it));
    endtask

    task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HEAP_CRIT)
            pr_crit = val;
        else
            pr_warn = val;
        @(posedge i_clk);
    endtask

    task automatic settle();
        int waited;
        waited     = 0;
        i_in_valid <= 1'b0;
        while (status_q.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        if (status_q.size() != 0) begin
            $error("results outstanding: %0d", status_q.size());
            fail_count++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic test_reset_status();
        send_item(mk(FN_SPARE, 3'd7, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
        send_item(mk(FN_PING, 3'd0, 32'h0, $urandom, $urandom));
        send_item(mk(FN_PING, 3'd7, 32'hFFFF_FFFF, $urandom, $urandom));
        send_item(mk(FN_PING, 3'd1, 32'd1, $urandom, $urandom));
    endtask

    task automatic test_timeout_load();
        int k;
        send_item(mk(FN_LOAD, 3'd0, $urandom, $urandom, 32'h0));
        send_item(mk(FN_LOAD, 3'd1, $urandom, $urandom, 32'hFFFF_FFFF));
        send_item(mk(FN_LOAD, 3'd2, $urandom, $urandom, 32'd100));
        for (k = 3; k < 7; k++)
            send_item(mk(FN_LOAD, k[2:0], $urandom, $urandom, 32'd1000));
        send_item(mk(FN_LOAD, 3'd7, $urandom, $urandom, 32'd50));
    endtask

    task automatic test_check_rules();
        send_item(mk(FN_CHECK, 3'($urandom), 32'd0, 32'hFFFF_FFFF, $urandom));
        send_item(mk(FN_PING, 3'd2, 32'd1000, $urandom, $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), 32'd500, 32'd32768, $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), 32'd1099, 32'd32767, $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), 32'd1100, 32'd16384, $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), 32'd1200, 32'd16383, $urandom));
        send_item(mk(FN_PING, 3'd2, 32'd1200, $urandom, $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), 32'd1201, 32'd16000, $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), 32'd1202, 32'd0, $urandom));
        send_item(mk(FN_PING, 3'd5, 32'd10, $urandom, $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), 32'd5000, 32'd0, $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), 32'd6000, 32'd0, $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), 32'd6001, 32'hFFFF_FFFF, $urandom));
        send_item(mk(FN_PING, 3'd5, 32'd6001, $urandom, $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), 32'hFFFF_FFFF, 32'd20000, $urandom));
    endtask

    task automatic test_thresholds();
        write_threshold(CFG_HEAP_CRIT, 32'h0);
        write_threshold(CFG_HEAP_WARN, 32'h0);
        send_item(mk(FN_CHECK, 3'($urandom), $urandom_range(7000, 8000), 32'h0, $urandom));
        settle();
        write_threshold(CFG_HEAP_CRIT, 32'hFFFF_FFFF);
        write_threshold(CFG_HEAP_WARN, 32'hFFFF_FFFF);
        send_item(mk(FN_CHECK, 3'($urandom), $urandom_range(7000, 8000), 32'hFFFF_FFFE,
                     $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), $urandom_range(7000, 8000), 32'hFFFF_FFFF,
                     $urandom));
        settle();
        write_threshold(CFG_HEAP_CRIT, 32'd1000);
        write_threshold(CFG_HEAP_WARN, 32'd500);
        send_item(mk(FN_CHECK, 3'($urandom), $urandom_range(7000, 8000), 32'd700, $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), $urandom_range(7000, 8000), 32'd999, $urandom));
        send_item(mk(FN_CHECK, 3'($urandom), $urandom_range(7000, 8000), 32'd1000, $urandom));
        settle();
        write_threshold(CFG_HEAP_CRIT, HEAP_CRIT_RST);
        write_threshold(CFG_HEAP_WARN, HEAP_WARN_RST);
    endtask

    task automatic test_counter_saturation();
        int k;
        send_item(mk(FN_PING, 3'd3, 32'd1, $urandom, $urandom));
        for (k = 0; k < 260; k++)
            send_item(mk(FN_CHECK, 3'($urandom), 32'd200000 + k,
                         $urandom_range(0, pr_crit - 1), $urandom));
    endtask

    task automatic test_random_mix(input int n_items, input logic [31:0] base);
        t_in_item it;
        int       r;
        int       k;
        clock_ms = base;
        for (k = 0; k < n_items; k++) begin
            r        = $urandom_range(99);
            clock_ms = clock_ms + $urandom_range(0, 40);
            it = mk(FN_PING, 3'($urandom_range(0, 7)), clock_ms, $urandom, $urandom);
            if (r < 40) begin
            end else if (r < 68) begin
                it.func      = FN_CHECK;
                it.free_heap = pick_heap();
            end else if (r < 80) begin
                it.func          = FN_LOAD;
                it.timeout_value = (r < 78) ? $urandom_range(20, 400) : $urandom;
            end else begin
                it.func   = 2'($urandom_range(0, 3));
                it.now_ms = $urandom;
            end
            send_item(it);
        end
    endtask

    task automatic test_backpressure();
        in_idle_en = 1'b0;
        hold_req++;
        test_random_mix(40, 32'd900000);
        settle();
        out_idle_en = 1'b0;
        test_random_mix(60, 32'd950000);
        settle();
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
    endtask

    initial begin : receiver
        int k;
        i_out_stall = 1'b0;
        hold_seen   = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                for (k = 0; k < 300; k++) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_out_stall <= out_idle_en && ($urandom_range(99) < 22);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                $error("result beat with no expectation waiting");
                fail_count++;
            end else begin
                exp_r = status_q.pop_front();
                if (o_out.alive_mask !== exp_r.alive_mask) begin
                    $error("alive_mask expected %0h actual %0h",
                           exp_r.alive_mask, o_out.alive_mask);
                    fail_count++;
                end
                if (o_out.heap_level !== exp_r.heap_level) begin
                    $error("heap_level expected %0d actual %0d",
                           exp_r.heap_level, o_out.heap_level);
                    fail_count++;
                end
                if (o_out.heap_low_mark !== exp_r.heap_low_mark) begin
                    $error("heap_low_mark expected %0h actual %0h",
                           exp_r.heap_low_mark, o_out.heap_low_mark);
                    fail_count++;
                end
                if (o_out.reboot_request !== exp_r.reboot_request) begin
                    $error("reboot_request expected %0b actual %0b",
                           exp_r.reboot_request, o_out.reboot_request);
                    fail_count++;
                end
                if (o_out.reboot_cause !== exp_r.reboot_cause) begin
                    $error("reboot_cause expected %0b actual %0b",
                           exp_r.reboot_cause, o_out.reboot_cause);
                    fail_count++;
                end
            end
        end
    end

    initial begin : run_limit
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : run
        int k;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        fail_count  = 0;
        hold_req    = 0;
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        clock_ms    = '0;
        for (k = 0; k < N_TASKS; k++) begin
            pr_stamp[k] = '0;
            pr_tmo[k]   = '0;
            pr_stale[k] = '0;
        end
        pr_strikes = '0;
        pr_low     = '1;
        pr_level   = LVL_OK;
        pr_alive   = '0;
        pr_crit    = HEAP_CRIT_RST;
        pr_warn    = HEAP_WARN_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_status();
        test_timeout_load();
        test_check_rules();
        settle();
        test_thresholds();
        test_counter_saturation();
        settle();
        write_threshold(CFG_HEAP_CRIT, $urandom_range(1000, 5000));
        write_threshold(CFG_HEAP_WARN, pr_crit + $urandom_range(0, 5000));
        test_random_mix(120, 32'd10000);
        settle();
        test_backpressure();
        write_threshold(CFG_HEAP_CRIT, $urandom);
        write_threshold(CFG_HEAP_WARN, $urandom);
        test_random_mix(120, 32'hFFFF_F000);
        settle();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/twhs_pkg.sv
rtl/core/twhs_ram.sv
rtl/core/twhs_slot_eval.sv
rtl/core/task_watchdog_heap_supervisor_unit.sv
bench/tb_top.sv
